>>> sv/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int COUNT_WIDTH_DEF = 24;   // default byte counter width
	localparam int TOTAL_WIDTH     = 24;   // width of the total_bytes port
	localparam int QUEUE_DEPTH     = 4;    // front-to-back command queue
	localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_UC_A  = 8'h41;
	localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LC_A  = 8'h61;
	localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
	localparam logic [7:0] CHAR_DIG_0 = 8'h30;
	localparam logic [7:0] CHAR_DIG_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_PAD   = 8'h3D;

	localparam logic [5:0] SEXT_LC_BASE  = 6'd26;
	localparam logic [5:0] SEXT_DIG_BASE = 6'd52;
	localparam logic [5:0] SEXT_PLUS     = 6'd62;
	localparam logic [5:0] SEXT_SLASH    = 6'd63;

	// Command from the front to the back: bytes of one closed group and/or
	// the end-of-text mark. nbytes == 0 only for an end mark without bytes.
	typedef struct packed {
		logic [2:0][7:0] bytes;   // bytes[0] is the first byte out
		logic [1:0]      nbytes;
		logic            done;
	} grp_cmd_t;

	typedef struct packed {
		logic       valid;   // in the alphabet or '='
		logic       pad;     // '='
		logic [5:0] val;
	} sext_t;

	function automatic sext_t sext_decode(input logic [7:0] c);
		sext_t r;
		r = '0;
		if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
			r.valid = 1'b1;
			r.val   = 6'(c - CHAR_UC_A);
		end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			r.valid = 1'b1;
			r.val   = SEXT_LC_BASE + 6'(c - CHAR_LC_A);
		end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			r.valid = 1'b1;
			r.val   = SEXT_DIG_BASE + 6'(c - CHAR_DIG_0);
		end else if (c == CHAR_PLUS) begin
			r.valid = 1'b1;
			r.val   = SEXT_PLUS;
		end else if (c == CHAR_SLASH) begin
			r.valid = 1'b1;
			r.val   = SEXT_SLASH;
		end else if (c == CHAR_PAD) begin
			r.valid = 1'b1;
			r.pad   = 1'b1;
		end
		return r;
	endfunction

endpackage

>>> sv/base64_stream_decoder_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake        | Transfer when      | Fields
// ---------+------------------+--------------------+-------------------------------------------
// input    | push / full      | push && !full      | char_code, has_char, end_of_text
// result   | pop / empty      | pop && !empty      | data_byte, byte_valid, text_done, total_bytes
//
// One input transfer per cycle is taken while the command queue has room; a result
// transfer can happen every cycle while the queue is not empty. A closed group gives one
// to three results from the back end; four characters make a group, so the output keeps up.
// A result reaches the ports once its command, registered in the queue, is at its head.
// arst_n clears group state, queue pointers and the byte counter; no clearing pass.
// Input and result sides stall independently through a four-entry command queue.
module base64_stream_decoder_core #(
	parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       char_code,
	input  logic                             has_char,
	input  logic                             end_of_text,
	output logic                             empty,
	input  logic                             pop,
	output logic [7:0]                       data_byte,
	output logic                             byte_valid,
	output logic                             text_done,
	output logic [b64d_pkg::TOTAL_WIDTH-1:0] total_bytes
);
	import b64d_pkg::*;

	logic     in_xfer;
	logic     cmd_wr;
	logic     cmd_rd;
	grp_cmd_t cmd_in;
	grp_cmd_t cmd_head;

	assign in_xfer = push & ~full;

	// front: classify the character and build groups
	b64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.xfer        (in_xfer),
		.char_code   (char_code),
		.has_char    (has_char),
		.end_of_text (end_of_text),
		.cmd_wr      (cmd_wr),
		.cmd         (cmd_in)
	);

	// queue of group / end commands; empty here is the result side's empty
	b64d_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.rd      (cmd_rd),
		.rd_data (cmd_head),
		.full    (full),
		.empty   (empty)
	);

	// back: sequence bytes of the head command and keep the running total
	b64d_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_head),
		.cmd_empty   (empty),
		.cmd_rd      (cmd_rd),
		.pop         (pop),
		.data_byte   (data_byte),
		.byte_valid  (byte_valid),
		.text_done   (text_done),
		.total_bytes (total_bytes)
	);

endmodule

>>> sv/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                xfer,
	input  logic [7:0]          char_code,
	input  logic                has_char,
	input  logic                end_of_text,
	output logic                cmd_wr,
	output b64d_pkg::grp_cmd_t  cmd
);
	import b64d_pkg::*;

	logic [23:0] bits_q;
	logic [1:0]  sext_cnt_q;
	logic [2:0]  pad_cnt_q;

	sext_t       sx;
	logic        take;
	logic        close;
	logic [23:0] bits_nxt;
	logic [2:0]  pad_nxt;

	assign sx       = sext_decode(char_code);
	assign take     = has_char & sx.valid;
	assign close    = take & (sext_cnt_q == 2'd3);
	assign bits_nxt = {bits_q[17:0], sx.pad ? 6'd0 : sx.val};
	assign pad_nxt  = pad_cnt_q + {2'b00, sx.pad};

	always_comb begin
		cmd       = '0;
		cmd.done  = end_of_text;
		if (close) begin
			cmd.bytes[0] = bits_nxt[23:16];
			cmd.bytes[1] = bits_nxt[15:8];
			cmd.bytes[2] = bits_nxt[7:0];
			if (pad_nxt == 3'd0) begin
				cmd.nbytes = 2'd3;
			end else if (pad_nxt == 3'd1) begin
				cmd.nbytes = 2'd2;
			end else begin
				cmd.nbytes = 2'd1;
			end
		end
	end

	assign cmd_wr = xfer & (close | end_of_text);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q     <= '0;
			sext_cnt_q <= '0;
			pad_cnt_q  <= '0;
		end else if (xfer) begin
			if (end_of_text || close) begin
				bits_q     <= '0;
				sext_cnt_q <= '0;
				pad_cnt_q  <= '0;
			end else if (take) begin
				bits_q     <= bits_nxt;
				sext_cnt_q <= sext_cnt_q + 2'd1;
				pad_cnt_q  <= pad_nxt;
			end
		end
	end

endmodule

>>> sv/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  b64d_pkg::grp_cmd_t  wr_data,
	input  logic                rd,
	output b64d_pkg::grp_cmd_t  rd_data,
	output logic                full,
	output logic                empty
);
	import b64d_pkg::*;

	grp_cmd_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_wr;
	logic do_rd;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr & ~full;
	assign do_rd   = rd & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back #(
	parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  b64d_pkg::grp_cmd_t             cmd,
	input  logic                           cmd_empty,
	output logic                           cmd_rd,
	input  logic                           pop,
	output logic [7:0]                     data_byte,
	output logic                           byte_valid,
	output logic                           text_done,
	output logic [b64d_pkg::TOTAL_WIDTH-1:0] total_bytes
);
	import b64d_pkg::*;

	logic [1:0]             idx_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic                               xfer;
	logic                               last;
	logic [COUNT_WIDTH-1:0]             cnt_inc;
	logic [COUNT_WIDTH-1:0]             cnt_show;
	logic [COUNT_WIDTH+TOTAL_WIDTH-1:0] cnt_ext;

	assign xfer       = pop & ~cmd_empty;
	assign byte_valid = (cmd.nbytes != 2'd0);
	assign last       = ~byte_valid | (idx_q == cmd.nbytes - 2'd1);
	assign text_done  = cmd.done & last;
	assign cmd_rd     = xfer & last;

	always_comb begin
		case (idx_q)
			2'd0:    data_byte = cmd.bytes[0];
			2'd1:    data_byte = cmd.bytes[1];
			2'd2:    data_byte = cmd.bytes[2];
			default: data_byte = '0;
		endcase
		if (!byte_valid) begin
			data_byte = '0;
		end
	end

	// count saturates at all ones
	assign cnt_inc     = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	assign cnt_show    = byte_valid ? cnt_inc : cnt_q;
	assign cnt_ext     = {{TOTAL_WIDTH{1'b0}}, cnt_show};
	assign total_bytes = cnt_ext[TOTAL_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else if (xfer) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
			if (text_done) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_show;
			end
		end
	end

endmodule
